>>> src/sblx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sinogram bin to LOR expander.
// Used by sblx_div and by the top level; depends on nothing else.
package sblx_pkg;

  // Table sizes.
  localparam int NUM_SINOS          = 128;
  localparam int MAX_PAIRS_PER_SINO = 16;
  localparam int SINO_W             = $clog2(NUM_SINOS);
  localparam int PAIR_IDX_W         = $clog2(MAX_PAIRS_PER_SINO);
  localparam int PAIR_CNT_W         = $clog2(MAX_PAIRS_PER_SINO + 1);
  localparam int MASH_LIMIT         = 4;

  // Widths of the fields.
  localparam int RING_W  = 6;
  localparam int VIEW_W  = 9;
  localparam int ELEM_W  = 8;
  localparam int ID_W    = 18;
  localparam int XTAL_W  = 10;

  // Shared divider widths.
  localparam int DIVD_W  = 18;
  localparam int DIVS_W  = 10;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_GAPS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_NOGAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIAL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ELEM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MASH       = 3'd5;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  // Answer from the shared divider; quotient and remainder are held until the next start.
  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [DIVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> src/sblx_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on sblx_pkg for widths and the request and answer structs.
module sblx_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sblx_pkg::div_req_t req,
  output sblx_pkg::div_rsp_t rsp
);
  import sblx_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;

  // One shift and trial subtract per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[DIVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIVD_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> src/sino_bin_to_lor_expander.sv
`timescale 1ns / 1ps
// Top level of the sinogram bin to LOR expander: span table, sequencer, output register.
// Depends on sblx_pkg and sblx_div.
//
// Usage: the input channel (in_valid/in_ready) takes load items (op 0), which
// append a ring pair to the list of a sinogram, and expand items (op 1), which
// turn a sinogram bin into one LOR per listed ring pair and per usable mash
// offset. Results leave on out_valid/out_ready, the final one with out_last set;
// when nothing qualifies a single result with out_lor_valid low is sent.
// Configuration registers are written on cfg_valid/cfg_ready; the user must
// write them only while idle, which the block itself does not enforce. A load
// passes through a read state and a write state; an expand is paced by the
// single shared 18-step divider used for wraps, gap removal and ring gap
// removal. The block takes no new item until the present one is finished.
// Results pass through one output register: a stalled receiver holds the
// transfer and the sequencer waits before overwriting it. Synchronous reset
// restores the register defaults, empties every pair list and drops any
// pending result; the ring pair store itself is not cleared.
module sino_bin_to_lor_expander (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [sblx_pkg::SINO_W-1:0]   in_sino_index,
  input  logic [sblx_pkg::RING_W-1:0]   in_ring_a,
  input  logic [sblx_pkg::RING_W-1:0]   in_ring_b,
  input  logic [sblx_pkg::VIEW_W-1:0]   in_view,
  input  logic [sblx_pkg::ELEM_W-1:0]   in_elem,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_lor_valid,
  output logic [sblx_pkg::ID_W-1:0]     out_crystal_id_a,
  output logic [sblx_pkg::ID_W-1:0]     out_crystal_id_b,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sblx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sblx_pkg::CFG_DAT_W-1:0] cfg_data
);
  import sblx_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LDRD  = 4'd1;
  localparam logic [3:0] S_LD    = 4'd2;
  localparam logic [3:0] S_XSET  = 4'd3;
  localparam logic [3:0] S_M1    = 4'd4;
  localparam logic [3:0] S_M2    = 4'd5;
  localparam logic [3:0] S_M3    = 4'd6;
  localparam logic [3:0] S_M4    = 4'd7;
  localparam logic [3:0] S_M5    = 4'd8;
  localparam logic [3:0] S_PRD   = 4'd9;
  localparam logic [3:0] S_PWAIT = 4'd10;
  localparam logic [3:0] S_P2    = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;
  localparam logic [3:0] S_DWAIT = 4'd14;

  localparam int CNT_DEPTH   = NUM_SINOS;
  localparam int STORE_DEPTH = NUM_SINOS * MAX_PAIRS_PER_SINO;
  localparam int PAIR_W      = 2 * RING_W;

  // Configuration registers.
  logic [9:0] ring_gaps_r;
  logic [5:0] head_r;
  logic [9:0] ring_nogap_r;
  logic [5:0] axial_r;
  logic [7:0] num_elem_r;
  logic [2:0] mash_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_gaps_r  <= 10'd672;
      head_r       <= 6'd13;
      ring_nogap_r <= 10'd624;
      axial_r      <= 6'd13;
      num_elem_r   <= 8'd160;
      mash_cfg_r   <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RING_GAPS:  ring_gaps_r  <= cfg_data;
        CFG_HEAD:       head_r       <= cfg_data[5:0];
        CFG_RING_NOGAP: ring_nogap_r <= cfg_data;
        CFG_AXIAL:      axial_r      <= cfg_data[5:0];
        CFG_NUM_ELEM:   num_elem_r   <= cfg_data[7:0];
        CFG_MASH:       mash_cfg_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Derived configuration values.
  logic [9:0] ring;
  logic [2:0] mash;
  logic [5:0] opti;
  assign ring = (ring_gaps_r == 10'd0) ? 10'd1 : ring_gaps_r;
  assign mash = (mash_cfg_r > 3'(MASH_LIMIT)) ? 3'(MASH_LIMIT) : mash_cfg_r;
  assign opti = num_elem_r[7:2];

  // Sequencer and item registers.
  logic [3:0]            state_r, state_nxt, ret_r, ret_nxt;
  logic                  op_r;
  logic [SINO_W-1:0]     sino_r;
  logic [RING_W-1:0]     ra_r, rb_r;
  logic [VIEW_W-1:0]     view_r;
  logic [ELEM_W-1:0]     elem_r;
  logic [PAIR_CNT_W-1:0] npairs_r, npairs_nxt, r_r, r_nxt;
  logic [2:0]            m_r, m_nxt;
  logic [XTAL_W-1:0]     x1_r, x1_nxt, x2_r, x2_nxt;
  logic [RING_W-1:0]     r1_r, r1_nxt;
  logic                  pend_r, pend_nxt;
  logic                  pend_lv_r, pend_lv_nxt;
  logic [ID_W-1:0]       pend_a_r, pend_a_nxt, pend_b_r, pend_b_nxt;

  // Output register.
  logic                  ov_r, ov_nxt, olv_r, olv_nxt, olast_r, olast_nxt;
  logic [ID_W-1:0]       oa_r, oa_nxt, ob_r, ob_nxt;
  logic                  can_push;
  assign can_push = !ov_r || out_ready;

  // Span table: pair counts with valid bits, and the ring pair store.
  logic [PAIR_CNT_W-1:0] cnt_mem [CNT_DEPTH];
  logic [CNT_DEPTH-1:0]  cnt_vld_r;
  logic [PAIR_CNT_W-1:0] cnt_q_r;
  logic                  cnt_qv_r;
  logic [PAIR_W-1:0]     store_mem [STORE_DEPTH];
  logic [PAIR_W-1:0]     store_q_r;
  logic [PAIR_CNT_W-1:0] cnt_cur;
  logic                  ld_wr;
  assign cnt_cur = cnt_qv_r ? cnt_q_r : '0;
  assign ld_wr   = (state_r == S_LD) && !op_r &&
                   (cnt_cur < PAIR_CNT_W'(MAX_PAIRS_PER_SINO));

  always_ff @(posedge clk) begin
    if (state_r == S_LDRD) begin
      cnt_q_r <= cnt_mem[sino_r];
    end
    if (ld_wr) begin
      cnt_mem[sino_r] <= cnt_cur + 1'b1;
      store_mem[{sino_r, cnt_cur[PAIR_IDX_W-1:0]}] <= {ra_r, rb_r};
    end
    if (state_r == S_PRD) begin
      store_q_r <= store_mem[{sino_r, r_r[PAIR_IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      cnt_qv_r  <= 1'b0;
    end else begin
      if (state_r == S_LDRD) begin
        cnt_qv_r <= cnt_vld_r[sino_r];
      end
      if (ld_wr) begin
        cnt_vld_r[sino_r] <= 1'b1;
      end
    end
  end

  // Shared divider.
  div_req_t dreq;
  div_rsp_t drsp;

  sblx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Crystal positions before wrapping, lifted by 128 rings to stay positive.
  logic [11:0]       base;
  logic [DIVD_W-1:0] lift, c1, c2;
  logic [6:0]        head_p1;
  logic [6:0]        axial_p1;
  logic [RING_W-1:0] r2_new;
  logic [ID_W-1:0]   id_a, id_b;
  logic [15:0]       prod_a, prod_b;

  assign base     = 12'(view_r) * 12'(mash) + 12'(m_r);
  assign lift     = {1'b0, ring, 7'd0};
  assign c1       = lift + DIVD_W'(base) + DIVD_W'(elem_r[7:1]) - DIVD_W'(opti);
  assign c2       = lift + DIVD_W'(base) + DIVD_W'(ring[9:1]) + DIVD_W'(opti)
                    - DIVD_W'((9'(elem_r) + 9'd1) >> 1);
  assign head_p1  = 7'(head_r) + 7'd1;
  assign axial_p1 = 7'(axial_r) + 7'd1;
  assign r2_new   = store_q_r[RING_W-1:0] - drsp.quotient[RING_W-1:0];
  assign prod_a   = r1_r * ring_nogap_r;
  assign prod_b   = r2_new * ring_nogap_r;
  assign id_a     = ID_W'(prod_a) + ID_W'(x1_r);
  assign id_b     = ID_W'(prod_b) + ID_W'(x2_r);

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    npairs_nxt  = npairs_r;
    r_nxt       = r_r;
    m_nxt       = m_r;
    x1_nxt      = x1_r;
    x2_nxt      = x2_r;
    r1_nxt      = r1_r;
    pend_nxt    = pend_r;
    pend_lv_nxt = pend_lv_r;
    pend_a_nxt  = pend_a_r;
    pend_b_nxt  = pend_b_r;
    ov_nxt      = ov_r && !out_ready;
    olv_nxt     = olv_r;
    olast_nxt   = olast_r;
    oa_nxt      = oa_r;
    ob_nxt      = ob_r;
    dreq        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LDRD;
        end
      end
      S_LDRD: begin
        state_nxt = op_r ? S_XSET : S_LD;
      end
      S_LD: begin
        state_nxt = S_IDLE;
      end
      S_XSET: begin
        npairs_nxt = cnt_cur;
        m_nxt      = '0;
        pend_nxt   = 1'b0;
        state_nxt  = S_M1;
      end
      // Wrap the first crystal, or finish once all offsets are done.
      S_M1: begin
        if (m_r == mash) begin
          state_nxt = S_FIN;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = c1;
          dreq.divisor  = ring;
          ret_nxt       = S_M2;
          state_nxt     = S_DWAIT;
        end
      end
      S_M2: begin
        x1_nxt        = drsp.remainder;
        dreq.start    = 1'b1;
        dreq.dividend = c2;
        dreq.divisor  = ring;
        ret_nxt       = S_M3;
        state_nxt     = S_DWAIT;
      end
      S_M3: begin
        x2_nxt        = drsp.remainder;
        dreq.start    = 1'b1;
        dreq.dividend = DIVD_W'(x1_r);
        dreq.divisor  = DIVS_W'(head_p1);
        ret_nxt       = S_M4;
        state_nxt     = S_DWAIT;
      end
      // Gap test and gap removal on the first crystal, then on the second.
      S_M4: begin
        if (drsp.remainder == DIVS_W'(head_r)) begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_M1;
        end else begin
          x1_nxt        = x1_r - drsp.quotient[XTAL_W-1:0];
          dreq.start    = 1'b1;
          dreq.dividend = DIVD_W'(x2_r);
          dreq.divisor  = DIVS_W'(head_p1);
          ret_nxt       = S_M5;
          state_nxt     = S_DWAIT;
        end
      end
      S_M5: begin
        if (drsp.remainder == DIVS_W'(head_r)) begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_M1;
        end else begin
          x2_nxt    = x2_r - drsp.quotient[XTAL_W-1:0];
          r_nxt     = '0;
          state_nxt = S_PRD;
        end
      end
      // Walk the ring pairs of the list.
      S_PRD: begin
        if (r_r == npairs_r) begin
          m_nxt     = m_r + 1'b1;
          state_nxt = S_M1;
        end else begin
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIVD_W'(store_q_r[PAIR_W-1:RING_W]);
        dreq.divisor  = DIVS_W'(axial_p1);
        ret_nxt       = S_P2;
        state_nxt     = S_DWAIT;
      end
      S_P2: begin
        r1_nxt        = store_q_r[PAIR_W-1:RING_W] - drsp.quotient[RING_W-1:0];
        dreq.start    = 1'b1;
        dreq.dividend = DIVD_W'(store_q_r[RING_W-1:0]);
        dreq.divisor  = DIVS_W'(axial_p1);
        ret_nxt       = S_EMIT;
        state_nxt     = S_DWAIT;
      end
      // Hold the new result back one step so that the last can be flagged.
      S_EMIT: begin
        if (!pend_r || can_push) begin
          if (pend_r) begin
            ov_nxt    = 1'b1;
            olv_nxt   = pend_lv_r;
            olast_nxt = 1'b0;
            oa_nxt    = pend_a_r;
            ob_nxt    = pend_b_r;
          end
          pend_nxt    = 1'b1;
          pend_lv_nxt = 1'b1;
          pend_a_nxt  = id_a;
          pend_b_nxt  = id_b;
          r_nxt       = r_r + 1'b1;
          state_nxt   = S_PRD;
        end
      end
      S_FIN: begin
        if (can_push) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          olv_nxt   = pend_r && pend_lv_r;
          oa_nxt    = pend_r ? pend_a_r : '0;
          ob_nxt    = pend_r ? pend_b_r : '0;
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_DWAIT: begin
        if (drsp.done) begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Item capture and payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_op;
      sino_r <= in_sino_index;
      ra_r   <= in_ring_a;
      rb_r   <= in_ring_b;
      view_r <= in_view;
      elem_r <= in_elem;
    end
    npairs_r  <= npairs_nxt;
    r_r       <= r_nxt;
    m_r       <= m_nxt;
    x1_r      <= x1_nxt;
    x2_r      <= x2_nxt;
    r1_r      <= r1_nxt;
    pend_lv_r <= pend_lv_nxt;
    pend_a_r  <= pend_a_nxt;
    pend_b_r  <= pend_b_nxt;
    olv_r     <= olv_nxt;
    olast_r   <= olast_nxt;
    oa_r      <= oa_nxt;
    ob_r      <= ob_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = ov_r;
  assign out_lor_valid    = olv_r;
  assign out_crystal_id_a = oa_r;
  assign out_crystal_id_b = ob_r;
  assign out_last         = olast_r;

endmodule

>>> src/sblx_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sinogram bin to LOR expander, bound to the top level.
// Depends on sblx_pkg for field widths.
module sblx_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_lor_valid,
  input logic [sblx_pkg::ID_W-1:0]     out_crystal_id_a,
  input logic [sblx_pkg::ID_W-1:0]     out_crystal_id_b,
  input logic                          out_last
);
  import sblx_pkg::*;

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_crystal_id_a)
      && $stable(out_crystal_id_b) && $stable(out_last) && $stable(out_lor_valid))
    else $error("stalled result changed");

  // Every item passes through further states, so the block is busy after a transfer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // An empty expansion is a single result that closes the item with zero ids.
  a_invalid_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lor_valid |-> out_last && out_crystal_id_a == '0
      && out_crystal_id_b == '0)
    else $error("invalid result malformed");

  // Reset drops any result.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind sino_bin_to_lor_expander sblx_checker u_sblx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_lor_valid    (out_lor_valid),
  .out_crystal_id_a (out_crystal_id_a),
  .out_crystal_id_b (out_crystal_id_b),
  .out_last         (out_last)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sino_bin_to_lor_expander: directed rows, then random phases.
// Depends on sblx_pkg and the expander RTL; the expected LORs come from a local predictor.
module tb;
  import sblx_pkg::*;

  localparam bit OP_LOAD   = 1'b0;
  localparam bit OP_EXPAND = 1'b1;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int NUM_PHASES = 6;
  localparam int NUM_REGS = 6;
  localparam int ITEMS_PER_PHASE = 58;

  typedef struct {
    bit            lor_valid;
    bit [ID_W-1:0] id_a;
    bit [ID_W-1:0] id_b;
    bit            last;
  } lor_t;

  typedef struct {
    bit                op;
    bit [SINO_W-1:0]   sino;
    bit [RING_W-1:0]   ring_a;
    bit [RING_W-1:0]   ring_b;
    bit [VIEW_W-1:0]   view;
    bit [ELEM_W-1:0]   elem;
    bit                typed;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [SINO_W-1:0]     in_sino_index;
  logic [RING_W-1:0]     in_ring_a;
  logic [RING_W-1:0]     in_ring_b;
  logic [VIEW_W-1:0]     in_view;
  logic [ELEM_W-1:0]     in_elem;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_lor_valid;
  logic [ID_W-1:0]       out_crystal_id_a;
  logic [ID_W-1:0]       out_crystal_id_b;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DAT_W-1:0]  cfg_data;

  // Predictor state: register copies and the span table.
  int unsigned ring_gaps, head_size, ring_nogap, axial_size, num_elem, mash_cfg;
  bit [4:0]          list_len [NUM_SINOS];
  bit [2*RING_W-1:0] pair_table [NUM_SINOS][MAX_PAIRS_PER_SINO];

  lor_t lor_q[$];
  int   mismatches;
  int   idle_cycles;
  int   calm_in, calm_out;

  sino_bin_to_lor_expander dut (.*);

  // Clock, 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int unsigned wrap_ring(input longint pos, input longint ring);
    longint m;
    m = pos % ring;
    if (m < 0) m += ring;
    return int'(m);
  endfunction

  function automatic void reset_predictor();
    ring_gaps = 672; head_size = 13; ring_nogap = 624;
    axial_size = 13; num_elem = 160; mash_cfg = 3;
    foreach (list_len[i]) list_len[i] = '0;
  endfunction

  function automatic void set_register(input bit [CFG_IDX_W-1:0] idx, input int unsigned v);
    case (idx)
      CFG_RING_GAPS:  ring_gaps  = v & 10'h3FF;
      CFG_HEAD:       head_size  = v & 6'h3F;
      CFG_RING_NOGAP: ring_nogap = v & 10'h3FF;
      CFG_AXIAL:      axial_size = v & 6'h3F;
      CFG_NUM_ELEM:   num_elem   = v & 8'hFF;
      CFG_MASH:       mash_cfg   = v & 3'h7;
      default: ;
    endcase
  endfunction

  // Append a ring pair unless the list is already full.
  function automatic void append_pair(input bit [SINO_W-1:0] s, input bit [RING_W-1:0] ra,
                                      input bit [RING_W-1:0] rb);
    if (list_len[s] < MAX_PAIRS_PER_SINO) begin
      pair_table[s][list_len[s]] = {ra, rb};
      list_len[s]++;
    end
  endfunction

  // Work out the LORs of one sinogram bin and queue them.
  function automatic void expand_bin(input bit [SINO_W-1:0] s, input bit [VIEW_W-1:0] v,
                                     input bit [ELEM_W-1:0] e);
    longint ring, mash, head, axial, opti, base, c1, c2;
    int unsigned x1, x2, r1, r2;
    int n;
    lor_t lor;
    ring  = (ring_gaps == 0) ? 1 : ring_gaps;
    mash  = (mash_cfg > MASH_LIMIT) ? MASH_LIMIT : mash_cfg;
    head  = head_size + 1;
    axial = axial_size + 1;
    opti  = num_elem / 4;
    n = 0;
    for (longint m = 0; m < mash; m++) begin
      base = longint'(v) * mash + m;
      c1 = base + longint'(e) / 2 - opti;
      c2 = base + ring / 2 - (longint'(e) + 1) / 2 + opti;
      x1 = wrap_ring(c1, ring);
      x2 = wrap_ring(c2, ring);
      // Offsets whose crystals touch a gap position are skipped.
      if ((x1 + 1) % head == 0 || (x2 + 1) % head == 0) continue;
      x1 -= x1 / head;
      x2 -= x2 / head;
      for (int r = 0; r < list_len[s]; r++) begin
        r1 = pair_table[s][r][2*RING_W-1:RING_W];
        r2 = pair_table[s][r][RING_W-1:0];
        r1 -= r1 / axial;
        r2 -= r2 / axial;
        lor.lor_valid = 1'b1;
        lor.id_a = ID_W'(r1 * ring_nogap + x1);
        lor.id_b = ID_W'(r2 * ring_nogap + x2);
        lor.last = 1'b0;
        lor_q.push_back(lor);
        n++;
      end
    end
    if (n == 0) begin
      lor = '{1'b0, '0, '0, 1'b1};
      lor_q.push_back(lor);
    end else begin
      lor_q[lor_q.size()-1].last = 1'b1;
    end
  endfunction

  // Mostly short gaps, a few long ones, and occasional stretches with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm = $urandom_range(20, 60);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item and hold it until the transfer happens.
  task automatic send_item(input stim_row_t row);
    int gap;
    lor_t none_found;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = row.op;
    in_sino_index = row.sino;
    in_ring_a = row.ring_a;
    in_ring_b = row.ring_b;
    in_view = row.view;
    in_elem = row.elem;
    do @(posedge clk); while (!in_ready);
    if (row.op == OP_LOAD) begin
      append_pair(row.sino, row.ring_a, row.ring_b);
    end else if (row.typed) begin
      // An empty list always gives the single invalid result.
      none_found = '{1'b0, '0, '0, 1'b1};
      lor_q.push_back(none_found);
    end else begin
      expand_bin(row.sino, row.view, row.elem);
    end
    @(negedge clk);
  endtask

  // Wait for the block to drain, then write all six registers.
  task automatic write_config(input int unsigned vals [NUM_REGS]);
    in_valid = 1'b0;
    while (lor_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid = 1'b1;
      cfg_index = CFG_IDX_W'(i);
      cfg_data = CFG_DAT_W'(vals[i]);
      do @(posedge clk); while (!cfg_ready);
      set_register(CFG_IDX_W'(i), vals[i]);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    bit [SINO_W-1:0] busy_sinos [6] = '{0, 1, 42, 85, 126, 127};
    row.typed = 1'b0;
    row.op = ($urandom_range(0, 99) < 40) ? OP_LOAD : OP_EXPAND;
    if ($urandom_range(0, 99) < 85) row.sino = busy_sinos[$urandom_range(0, 5)];
    else row.sino = SINO_W'($urandom_range(0, NUM_SINOS - 1));
    row.ring_a = ($urandom_range(0, 4) == 0) ? {RING_W{$urandom_range(0, 1) == 1}}
                                             : RING_W'($urandom_range(0, 63));
    row.ring_b = ($urandom_range(0, 4) == 0) ? {RING_W{$urandom_range(0, 1) == 1}}
                                             : RING_W'($urandom_range(0, 63));
    row.view = ($urandom_range(0, 6) == 0) ? {VIEW_W{$urandom_range(0, 1) == 1}}
                                           : VIEW_W'($urandom_range(0, 511));
    row.elem = ($urandom_range(0, 6) == 0) ? {ELEM_W{$urandom_range(0, 1) == 1}}
                                           : ELEM_W'($urandom_range(0, 255));
    return row;
  endfunction

  // Receiver: random stalls on the result channel.
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = pick_gap(calm_out);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    lor_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lor_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = lor_q.pop_front();
        if (out_lor_valid !== want.lor_valid)
          report($sformatf("lor_valid %b, expected %b", out_lor_valid, want.lor_valid));
        if (out_crystal_id_a !== want.id_a)
          report($sformatf("crystal_id_a %0d, expected %0d", out_crystal_id_a, want.id_a));
        if (out_crystal_id_b !== want.id_b)
          report($sformatf("crystal_id_b %0d, expected %0d", out_crystal_id_b, want.id_b));
        if (out_last !== want.last)
          report($sformatf("last %b, expected %b", out_last, want.last));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t directed [15] = '{
      '{OP_EXPAND, 0,   0,  0,  0,   0,   1'b1},
      '{OP_EXPAND, 127, 0,  0,  511, 255, 1'b1},
      '{OP_LOAD,   0,   0,  0,  0,   0,   1'b0},
      '{OP_LOAD,   0,   63, 63, 0,   0,   1'b0},
      '{OP_LOAD,   0,   13, 14, 0,   0,   1'b0},
      '{OP_LOAD,   127, 63, 0,  0,   0,   1'b0},
      '{OP_LOAD,   127, 0,  63, 0,   0,   1'b0},
      '{OP_EXPAND, 0,   0,  0,  0,   0,   1'b0},
      '{OP_EXPAND, 0,   0,  0,  511, 255, 1'b0},
      '{OP_EXPAND, 127, 0,  0,  255, 128, 1'b0},
      '{OP_EXPAND, 0,   0,  0,  3,   80,  1'b0},
      '{OP_EXPAND, 127, 0,  0,  0,   255, 1'b0},
      '{OP_LOAD,   42,  42, 21, 0,   0,   1'b0},
      '{OP_EXPAND, 42,  0,  0,  170, 85,  1'b0},
      '{OP_EXPAND, 85,  0,  0,  341, 170, 1'b1}
    };
    // Register settings per random phase: defaults, maxima, minima, out-of-range
    // mash with a zero ring, zero head, axial, element count and mash, and one random setting.
    int unsigned settings [NUM_PHASES][NUM_REGS];
    settings[0] = '{672, 13, 624, 13, 160, 3};
    settings[1] = '{1023, 63, 1023, 63, 255, 4};
    settings[2] = '{2, 1, 1, 1, 4, 1};
    settings[3] = '{0, 5, 100, 7, 3, 7};
    settings[4] = '{$urandom_range(2, 1023), 0, $urandom_range(1, 1023), 0, 0, 0};
    settings[5] = '{$urandom_range(2, 1023), $urandom_range(1, 63), $urandom_range(1, 1023),
                    $urandom_range(1, 63), $urandom_range(4, 255), $urandom_range(1, 4)};

    mismatches = 0;
    idle_cycles = 0;
    calm_in = 0;
    calm_out = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_sino_index = '0;
    in_ring_a = '0;
    in_ring_b = '0;
    in_view = '0;
    in_elem = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RING_GAPS;
    cfg_data = '0;
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows with the reset settings.
    foreach (directed[i]) send_item(directed[i]);

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_config(settings[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_item(random_row());
    end

    in_valid = 1'b0;
    while (lor_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
